FILE: rtl/core/utp_pkg.sv
package utp_pkg;

    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] DIGITS_TOTAL = 6'd32;
    localparam logic [CNT_W-1:0] GROUP_A      = 6'd8;
    localparam logic [CNT_W-1:0] GROUP_B      = 6'd12;
    localparam logic [CNT_W-1:0] GROUP_C      = 6'd16;
    localparam logic [CNT_W-1:0] GROUP_D      = 6'd20;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;

    typedef struct packed {
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic        valid_res;
    } t_result;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [4:0] v;
        if (ch >= CH_0 && ch <= CH_9) begin
            v = {1'b0, ch[3:0]};
        end else if ((ch >= CH_LO_A && ch <= CH_LO_F) || (ch >= CH_UP_A && ch <= CH_UP_F)) begin
            v = {1'b0, ch[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/uuid_text_parser.sv
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_kind, i_symbol
// output  | o_valid | i_stall | o_value_high, o_value_low, o_valid_res
//
// One transfer in per cycle, back to back, while o_stall is low; a character
// passes through the input register without stalling. An end marker's result
// is loaded into the output register at the edge that empties the input register.
// Reset is synchronous, active low, and clears parse state but not data registers.
// o_stall rises only while an end marker waits on a full, stalled output register.
module uuid_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_symbol,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_value_high,
    output logic [63:0] o_value_low,
    output logic        o_valid_res
);

    logic             res_valid;
    logic             res_ready;
    utp_pkg::t_result res;
    utp_pkg::t_result out_res;

    utp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_symbol    (i_symbol),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    utp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (out_res)
    );

    assign o_value_high = out_res.value_high;
    assign o_value_low  = out_res.value_low;
    assign o_valid_res  = out_res.valid_res;

endmodule

FILE: rtl/core/utp_parse.sv
module utp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_kind,
    input  logic [7:0]         i_symbol,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output utp_pkg::t_result   o_res
);

    typedef struct packed {
        logic [63:0]               acc_high;
        logic [63:0]               acc_low;
        logic [utp_pkg::CNT_W-1:0] digit_count;
        logic                      seen_first;
        logic                      brace_open;
        logic                      dashed_form;
        logic                      dash_taken;
        logic                      brace_closed;
        logic                      error_latched;
    } t_state;

    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_symbol;
    t_state     r_st;
    t_state     n_st;
    logic       consume;
    logic       ok;
    logic [4:0] nib;
    logic       is_group;

    assign consume = r_in_valid && (r_kind == utp_pkg::KIND_CHAR || i_res_ready);
    assign o_stall = r_in_valid && !consume;

    assign nib      = utp_pkg::hex_nibble(r_symbol);
    assign is_group = (r_st.digit_count == utp_pkg::GROUP_B)
                   || (r_st.digit_count == utp_pkg::GROUP_C)
                   || (r_st.digit_count == utp_pkg::GROUP_D);

    assign ok = !r_st.error_latched && r_st.seen_first
             && r_st.digit_count == utp_pkg::DIGITS_TOTAL
             && (!r_st.brace_open || r_st.brace_closed);

    assign o_res_valid       = r_in_valid && r_kind == utp_pkg::KIND_END;
    assign o_res.value_high  = ok ? r_st.acc_high : 64'd0;
    assign o_res.value_low   = ok ? r_st.acc_low  : 64'd0;
    assign o_res.valid_res   = ok;

    always_comb begin
        n_st = r_st;
        if (consume) begin
            if (r_kind == utp_pkg::KIND_END) begin
                n_st = '0;
            end else if (!r_st.error_latched) begin
                n_st.seen_first = 1'b1;
                if (!r_st.seen_first && r_symbol == utp_pkg::CH_LBRACE) begin
                    n_st.brace_open = 1'b1;
                end else if (r_st.brace_closed) begin
                    n_st.error_latched = 1'b1;
                end else if (r_st.digit_count >= utp_pkg::DIGITS_TOTAL) begin
                    if (r_st.brace_open && r_symbol == utp_pkg::CH_RBRACE) begin
                        n_st.brace_closed = 1'b1;
                    end else begin
                        n_st.error_latched = 1'b1;
                    end
                end else if (r_st.digit_count == utp_pkg::GROUP_A && !r_st.dash_taken
                             && r_symbol == utp_pkg::CH_DASH) begin
                    n_st.dashed_form = 1'b1;
                    n_st.dash_taken  = 1'b1;
                end else if (is_group && r_st.dashed_form && !r_st.dash_taken) begin
                    if (r_symbol == utp_pkg::CH_DASH) begin
                        n_st.dash_taken = 1'b1;
                    end else begin
                        n_st.error_latched = 1'b1;
                    end
                end else if (nib[4]) begin
                    n_st.error_latched = 1'b1;
                end else begin
                    n_st.acc_high    = {r_st.acc_high[59:0], r_st.acc_low[63:60]};
                    n_st.acc_low     = {r_st.acc_low[59:0], nib[3:0]};
                    n_st.digit_count = r_st.digit_count + 6'd1;
                    n_st.dash_taken  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= '0;
        end else begin
            r_st <= n_st;
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_kind   <= i_kind;
            r_symbol <= i_symbol;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.digit_count <= utp_pkg::DIGITS_TOTAL)
        else $error("digit count beyond 32");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_kind == utp_pkg::KIND_END) |=>
            (r_st.digit_count == '0 && !r_st.error_latched && !r_st.seen_first))
        else $error("state not cleared after end marker");

    a_close_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.brace_closed |-> (r_st.brace_open && r_st.digit_count == utp_pkg::DIGITS_TOTAL))
        else $error("closing brace without opening brace or full digits");

    a_dash_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.dash_taken |-> r_st.dashed_form)
        else $error("dash taken outside dashed form");

    a_valid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.valid_res) |-> !r_st.error_latched)
        else $error("valid result with latched error");
`endif

endmodule

FILE: rtl/core/utp_out.sv
module utp_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    output logic             o_res_ready,
    input  utp_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_stall,
    output utp_pkg::t_result o_res
);

    logic             r_valid;
    utp_pkg::t_result r_res;

    assign o_res_ready = !r_valid || !i_stall;
    assign o_valid     = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule
